// ----- rtl/bst_pkg.sv -----
package bst_pkg;

  localparam int unsigned DepthW = 7;

  typedef enum logic [4:0] {
    MODE_IDLE       = 5'b00001,
    MODE_INT_START  = 5'b00010,
    MODE_INT_DIGITS = 5'b00100,
    MODE_LEN_DIGITS = 5'b01000,
    MODE_STR_DATA   = 5'b10000
  } mode_e;

  typedef enum logic [2:0] {
    TOK_INT      = 3'd0,
    TOK_STR_HDR  = 3'd1,
    TOK_STR_BYTE = 3'd2,
    TOK_LIST     = 3'd3,
    TOK_DICT     = 3'd4,
    TOK_END      = 3'd5,
    TOK_ERROR    = 3'd7
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_BYTE  = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_STR_LONG  = 3'd3,
    ERR_TOO_DEEP  = 3'd4,
    ERR_STRAY_END = 3'd5
  } err_e;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // floor((2^63 - 1) / 10); the per-digit bound is this or one less
  localparam logic [63:0] IntLimitDiv10 = 64'd922337203685477580;

  typedef struct packed {
    mode_e              mode;
    logic [63:0]        acc;
    logic               neg;
    logic [31:0]        bytes_left;
    logic [DepthW-1:0]  depth;
  } bst_state_t;

  typedef struct packed {
    token_kind_e        kind;
    logic signed [63:0] int_value;
    logic [31:0]        str_len;
    logic [7:0]         str_byte;
    logic [DepthW-1:0]  depth;
    logic               last;
    logic               complete;
    err_e               err;
  } bst_result_t;

endpackage

// ----- rtl/bst_step.sv -----
module bst_step #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  bst_pkg::bst_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic [31:0]          max_len_i,
  output bst_pkg::bst_state_t  state_o,
  output logic                 emit_o,
  output bst_pkg::bst_result_t result_o
);

  localparam logic [bst_pkg::DepthW-1:0] MaxDepthW = bst_pkg::DepthW'(MAX_DEPTH);

  logic                        is_digit;
  logic [3:0]                  digit;
  logic [63:0]                 thresh;
  logic                        thresh_adj;
  logic [63:0]                 acc_x10;
  logic [35:0]                 len_x10;
  logic [63:0]                 neg_val;
  logic [31:0]                 bytes_dec;
  logic [bst_pkg::DepthW-1:0]  depth_inc;
  logic [bst_pkg::DepthW-1:0]  depth_dec;
  logic                        err;
  bst_pkg::err_e               err_code;

  assign is_digit  = byte_i inside {[bst_pkg::CH_0:bst_pkg::CH_9]};
  assign digit     = byte_i[3:0];
  // bound drops by one for digits 8,9 (positive) or 9 (negative)
  assign thresh_adj = state_i.neg ? (digit == 4'd9) : (digit >= 4'd8);
  assign thresh    = bst_pkg::IntLimitDiv10 - 64'(thresh_adj);
  assign acc_x10   = (state_i.acc << 3) + (state_i.acc << 1) + 64'(digit);
  assign len_x10   = ({4'd0, state_i.acc[31:0]} << 3) + ({4'd0, state_i.acc[31:0]} << 1)
                   + 36'(digit);
  assign neg_val   = 64'd0 - state_i.acc;
  assign bytes_dec = state_i.bytes_left - 32'd1;
  assign depth_inc = state_i.depth + 1'b1;
  assign depth_dec = state_i.depth - 1'b1;

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    err      = 1'b0;
    err_code = bst_pkg::ERR_NONE;
    result_o = '0;
    result_o.kind  = bst_pkg::TOK_INT;
    result_o.err   = bst_pkg::ERR_NONE;
    result_o.depth = state_i.depth;

    case (state_i.mode)
      bst_pkg::MODE_INT_START, bst_pkg::MODE_INT_DIGITS: begin
        if (state_i.mode == bst_pkg::MODE_INT_START && byte_i == bst_pkg::CH_MINUS &&
            !state_i.neg) begin
          state_o.neg  = 1'b1;
          state_o.mode = bst_pkg::MODE_INT_DIGITS;
        end else if (is_digit) begin
          if (state_i.acc > thresh) begin
            err      = 1'b1;
            err_code = bst_pkg::ERR_OVERFLOW;
          end else begin
            state_o.acc  = acc_x10;
            state_o.mode = bst_pkg::MODE_INT_DIGITS;
          end
        end else if (byte_i == bst_pkg::CH_E) begin
          state_o.mode       = bst_pkg::MODE_IDLE;
          state_o.acc        = '0;
          state_o.neg        = 1'b0;
          emit_o             = 1'b1;
          result_o.kind      = bst_pkg::TOK_INT;
          result_o.int_value = state_i.neg ? neg_val : state_i.acc;
          result_o.complete  = (state_i.depth == '0);
        end else begin
          err      = 1'b1;
          err_code = bst_pkg::ERR_BAD_BYTE;
        end
      end
      bst_pkg::MODE_LEN_DIGITS: begin
        if (is_digit) begin
          if (len_x10 > {4'd0, max_len_i}) begin
            err      = 1'b1;
            err_code = bst_pkg::ERR_STR_LONG;
          end else begin
            state_o.acc = 64'(len_x10);
          end
        end else if (byte_i == bst_pkg::CH_COLON) begin
          state_o.acc      = '0;
          emit_o           = 1'b1;
          result_o.kind    = bst_pkg::TOK_STR_HDR;
          result_o.str_len = state_i.acc[31:0];
          if (state_i.acc[31:0] == '0) begin
            state_o.mode      = bst_pkg::MODE_IDLE;
            result_o.complete = (state_i.depth == '0);
          end else begin
            state_o.bytes_left = state_i.acc[31:0];
            state_o.mode       = bst_pkg::MODE_STR_DATA;
          end
        end else begin
          err      = 1'b1;
          err_code = bst_pkg::ERR_BAD_BYTE;
        end
      end
      bst_pkg::MODE_STR_DATA: begin
        state_o.bytes_left = bytes_dec;
        emit_o             = 1'b1;
        result_o.kind      = bst_pkg::TOK_STR_BYTE;
        result_o.str_byte  = byte_i;
        result_o.last      = (bytes_dec == '0);
        result_o.complete  = (bytes_dec == '0) && (state_i.depth == '0);
        if (bytes_dec == '0) begin
          state_o.mode = bst_pkg::MODE_IDLE;
        end
      end
      default: begin
        state_o.mode = bst_pkg::MODE_IDLE;
        if (byte_i == bst_pkg::CH_I) begin
          state_o.mode = bst_pkg::MODE_INT_START;
          state_o.acc  = '0;
          state_o.neg  = 1'b0;
        end else if (is_digit) begin
          if ({28'd0, digit} > max_len_i) begin
            err      = 1'b1;
            err_code = bst_pkg::ERR_STR_LONG;
          end else begin
            state_o.acc  = 64'(digit);
            state_o.mode = bst_pkg::MODE_LEN_DIGITS;
          end
        end else if (byte_i == bst_pkg::CH_L || byte_i == bst_pkg::CH_D) begin
          if (state_i.depth >= MaxDepthW) begin
            err      = 1'b1;
            err_code = bst_pkg::ERR_TOO_DEEP;
          end else begin
            state_o.depth  = depth_inc;
            emit_o         = 1'b1;
            result_o.kind  = (byte_i == bst_pkg::CH_L) ? bst_pkg::TOK_LIST : bst_pkg::TOK_DICT;
            result_o.depth = depth_inc;
          end
        end else if (byte_i == bst_pkg::CH_E) begin
          if (state_i.depth == '0) begin
            err      = 1'b1;
            err_code = bst_pkg::ERR_STRAY_END;
          end else begin
            state_o.depth     = depth_dec;
            emit_o            = 1'b1;
            result_o.kind     = bst_pkg::TOK_END;
            result_o.depth    = depth_dec;
            result_o.complete = (depth_dec == '0);
          end
        end else begin
          err      = 1'b1;
          err_code = bst_pkg::ERR_BAD_BYTE;
        end
      end
    endcase

    // any error resyncs to idle at depth 0
    if (err) begin
      state_o            = '0;
      state_o.mode       = bst_pkg::MODE_IDLE;
      emit_o             = 1'b1;
      result_o           = '0;
      result_o.kind      = bst_pkg::TOK_ERROR;
      result_o.err       = err_code;
    end
  end

endmodule

// ----- rtl/bencode_stream_tokenizer_top.sv -----
// An item is registered at acceptance, then processed into a registered token on the outputs;
// items that only update state give none.
// Throughput: one byte per cycle; a held token stalls only a byte that produces a token.
// Reset (rst_ni low, asynchronous): parser idle at depth 0, both stages empty,
// max_string_length back to all ones.
module bencode_stream_tokenizer_top #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         token_kind_o,
  output logic signed [63:0] integer_value_o,
  output logic [31:0]        string_length_o,
  output logic [7:0]         string_byte_o,
  output logic [6:0]         nesting_depth_o,
  output logic               last_of_string_o,
  output logic               value_complete_o,
  output logic [2:0]         error_code_o
);

  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  logic [31:0]          max_len_q;
  bst_pkg::bst_state_t  state_q, state_d;
  bst_pkg::bst_result_t res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic                 emit;
  logic                 out_free;
  logic                 proc;
  logic                 accept;

  bst_step #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .max_len_i(max_len_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (res_d)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  // silent bytes advance even while the output holds a token
  assign proc       = in_valid_q && (out_free || !emit);
  assign in_stall_o = in_valid_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc && emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_len_q   <= '1;
      state_q     <= '{mode: bst_pkg::MODE_IDLE, default: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
    end
    if (proc && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign token_kind_o     = res_q.kind;
  assign integer_value_o  = res_q.int_value;
  assign string_length_o  = res_q.str_len;
  assign string_byte_o    = res_q.str_byte;
  assign nesting_depth_o  = res_q.depth;
  assign last_of_string_o = res_q.last;
  assign value_complete_o = res_q.complete;
  assign error_code_o     = res_q.err;

`ifndef SYNTHESIS
  a_err_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == bst_pkg::TOK_ERROR |->
      res_q.depth == '0 && res_q.err != bst_pkg::ERR_NONE)
    else $error("error token with nonzero depth or no code");

  a_err_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != bst_pkg::TOK_ERROR |-> res_q.err == bst_pkg::ERR_NONE)
    else $error("error code on a non-error token");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.depth) <= MAX_DEPTH)
    else $error("nesting depth beyond limit");

  a_str_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == bst_pkg::MODE_STR_DATA |-> state_q.bytes_left != '0)
    else $error("string data mode with no bytes left");
`endif

endmodule
